[hw/rtl/two_level_local_branch_predictor_defines.svh]
// ----------------------------------------------------------------------------
// Two-level local branch predictor: assertion macros
// Concurrent assertion helpers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_LOCAL_BRANCH_PREDICTOR_DEFINES_SVH
`define TWO_LEVEL_LOCAL_BRANCH_PREDICTOR_DEFINES_SVH

`ifndef SYNTH
// assertion on an explicit clock and active-low reset
`define TLLBP_ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tllbp assertion failed");
// assertion on the block's own clock and reset
`define TLLBP_ASSERT(name, prop) `TLLBP_ASSERT_CLK(name, clk_i, rst_ni, prop)
`else
`define TLLBP_ASSERT_CLK(name, clk, rst_n, prop)
`define TLLBP_ASSERT(name, prop)
`endif

`endif

[hw/rtl/tllbp_pkg.sv]
// ----------------------------------------------------------------------------
// Two-level local branch predictor: package
// Beat types and fixed field widths shared by the predictor modules.
// ----------------------------------------------------------------------------
package tllbp_pkg;

  localparam int IDX_W       = 16;
  localparam int MISS_W      = 16;
  localparam int ENTRY_OUT_W = 4;
  localparam int CTR_W       = 2;
  localparam int CFG_W       = 3;

  localparam logic [CFG_W-1:0] CFG_RESET = 3'd1;
  localparam logic [CTR_W-1:0] CTR_MAX   = 2'd3;
  localparam logic [CTR_W-1:0] CTR_MIN   = 2'd0;

  // input beat
  typedef struct packed {
    logic [IDX_W-1:0] inst_index;
    logic             taken;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic                   predicted_taken;
    logic                   correct;
    logic [ENTRY_OUT_W-1:0] entry_used;
    logic [MISS_W-1:0]      mispredict_count;
  } out_beat_t;

endpackage

[hw/rtl/two_level_local_branch_predictor.sv]
// ----------------------------------------------------------------------------
// Two-level local branch predictor: top level
// Per-entry local history selects a 2-bit counter; reports and updates.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i / in_ready_o / in_data_i): one beat per executed
//     instruction, its sequence index and actual outcome.
//   out channel (out_valid_o / out_ready_i / out_data_o): one beat per input
//     beat, in order: prediction, correct flag, entry used, miss count.
//   cfg channel (cfg_valid_i / cfg_ready_o / cfg_data_i): log2 of entries in
//     use; always ready, write only while no beat is in flight.
// Path: an accepted beat passes the read stage, then the result register
//   driving out_data_o. Throughput: one beat per cycle unless out_ready_i
//   stalls; the row is read at accept and written back as the beat leaves
//   the read stage, a one-row bypass covering back-to-back same-entry beats.
// Reset: entry count log2 returns to 1; every entry reads as all zero
//   (history, counters, miss count) until first written, tracked by one
//   valid flop per entry.
// Stall: with out_ready_i low the result register holds; one more beat can
//   sit in the read stage, after which in_ready_o drops.
// ----------------------------------------------------------------------------
`include "two_level_local_branch_predictor_defines.svh"

module two_level_local_branch_predictor #(
  parameter int MAX_ENTRIES  = 16,
  parameter int HISTORY_BITS = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tllbp_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tllbp_pkg::in_beat_t           in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tllbp_pkg::out_beat_t          out_data_o
);

  localparam int EntryW  = $clog2(MAX_ENTRIES);
  localparam int CtrsW   = tllbp_pkg::CTR_W << HISTORY_BITS;
  localparam int RowW    = tllbp_pkg::MISS_W + CtrsW + HISTORY_BITS;
  localparam int MaxLog2 = $clog2(MAX_ENTRIES + 1) - 1;
  localparam int LgCap   = (MaxLog2 > 7) ? 7 : MaxLog2;

  logic [tllbp_pkg::CFG_W-1:0] cfg_q;
  logic [tllbp_pkg::CFG_W-1:0] lg;
  logic [EntryW-1:0]           mask;
  logic [EntryW-1:0]           rd_entry;
  logic                        in_acc;
  logic                        s1_advance;
  logic                        we;
  logic                        s1_valid_q;
  logic [EntryW-1:0]           s1_entry_q;
  logic                        s1_taken_q;
  logic                        s1_hit_q;
  logic                        s1_rvalid_q;
  logic [RowW-1:0]             rdata;
  logic [RowW-1:0]             row;
  logic [RowW-1:0]             row_n;
  logic [RowW-1:0]             byp_row_q;
  logic [MAX_ENTRIES-1:0]      valid_q;
  logic                        out_valid_q;
  tllbp_pkg::out_beat_t        res;
  tllbp_pkg::out_beat_t        out_beat_q;

  // configuration register, always ready
  assign cfg_ready_o = 1'b1;

  // effective log2 entry count: zero acts as one, clamp to what fits
  always_comb begin
    lg = cfg_q;
    if (lg == '0) lg = tllbp_pkg::CFG_W'(1);
    if (int'(lg) > LgCap) lg = tllbp_pkg::CFG_W'(LgCap);
  end

  // entry select: index modulo the entry count
  always_comb begin
    for (int i = 0; i < EntryW; i++) begin
      mask[i] = (i < int'(lg));
    end
  end
  assign rd_entry = in_data_i.inst_index[EntryW-1:0] & mask;

  // handshake between read stage and result register
  assign s1_advance = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_acc     = in_valid_i && in_ready_o;
  assign we         = s1_valid_q && s1_advance;

  // entry rows: history, counters and miss count of one entry
  tllbp_ram #(
    .WIDTH (RowW),
    .DEPTH (MAX_ENTRIES)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (s1_entry_q),
    .wdata_i (row_n),
    .re_i    (in_acc),
    .raddr_i (rd_entry),
    .rdata_o (rdata)
  );

  // row seen by the read stage: bypass, memory, or reset value
  assign row = s1_hit_q ? byp_row_q : (s1_rvalid_q ? rdata : '0);

  tllbp_update #(
    .HISTORY_BITS (HISTORY_BITS),
    .ENTRY_W      (EntryW)
  ) u_update (
    .row_i   (row),
    .entry_i (s1_entry_q),
    .taken_i (s1_taken_q),
    .row_o   (row_n),
    .res_o   (res)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= tllbp_pkg::CFG_RESET;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) cfg_q <= cfg_data_i;
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (s1_advance) out_valid_q <= s1_valid_q;
      if (we) valid_q[s1_entry_q] <= 1'b1;
    end
  end

  // read stage and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_entry_q  <= rd_entry;
      s1_taken_q  <= in_data_i.taken;
      s1_hit_q    <= we && (s1_entry_q == rd_entry);
      s1_rvalid_q <= valid_q[rd_entry];
    end
    if (we) begin
      byp_row_q  <= row_n;
      out_beat_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_beat_q;

  // checks
  `TLLBP_ASSERT(a_accept_fills_stage, in_valid_i && in_ready_o |=> s1_valid_q)
  `TLLBP_ASSERT(a_backpressure_cause, !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
  `TLLBP_ASSERT(a_bypass_entry_valid, s1_valid_q && s1_hit_q |-> valid_q[s1_entry_q])
  `TLLBP_ASSERT(a_lg_in_range, lg != '0 && int'(lg) <= LgCap)

endmodule

[hw/rtl/tllbp_ram.sv]
// ----------------------------------------------------------------------------
// Two-level local branch predictor: generic RAM
// One write port, one read port, registered read data (read-first).
// ----------------------------------------------------------------------------
module tllbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/tllbp_update.sv]
// ----------------------------------------------------------------------------
// Two-level local branch predictor: entry update
// Predicts from one entry row and builds the updated row and the result.
// Row layout, msb first: miss count, pattern counters, local history.
// ----------------------------------------------------------------------------
module tllbp_update #(
  parameter int HISTORY_BITS = 3,
  parameter int ENTRY_W      = 4
) (
  input  logic [tllbp_pkg::MISS_W + (tllbp_pkg::CTR_W << HISTORY_BITS)
                + HISTORY_BITS - 1:0] row_i,
  input  logic [ENTRY_W-1:0]           entry_i,
  input  logic                         taken_i,
  output logic [tllbp_pkg::MISS_W + (tllbp_pkg::CTR_W << HISTORY_BITS)
                + HISTORY_BITS - 1:0] row_o,
  output tllbp_pkg::out_beat_t         res_o
);

  localparam int NumCtrs = 1 << HISTORY_BITS;
  localparam int CtrsW   = tllbp_pkg::CTR_W * NumCtrs;
  localparam int ExtW    = (ENTRY_W > tllbp_pkg::ENTRY_OUT_W) ? ENTRY_W
                                                              : tllbp_pkg::ENTRY_OUT_W;

  logic [HISTORY_BITS-1:0]      hist;
  logic [HISTORY_BITS-1:0]      hist_n;
  logic [CtrsW-1:0]             ctrs;
  logic [CtrsW-1:0]             ctrs_n;
  logic [tllbp_pkg::CTR_W-1:0]  ctr;
  logic [tllbp_pkg::CTR_W-1:0]  ctr_n;
  logic [tllbp_pkg::MISS_W-1:0] miss;
  logic [tllbp_pkg::MISS_W-1:0] miss_n;
  logic                         pred;
  logic                         ok;
  logic [ExtW-1:0]              entry_ext;

  // unpack the row
  assign hist = row_i[HISTORY_BITS-1:0];
  assign ctrs = row_i[HISTORY_BITS +: CtrsW];
  assign miss = row_i[HISTORY_BITS + CtrsW +: tllbp_pkg::MISS_W];

  // prediction from the counter the history selects
  assign ctr  = ctrs[hist * tllbp_pkg::CTR_W +: tllbp_pkg::CTR_W];
  assign pred = ctr[tllbp_pkg::CTR_W-1];
  assign ok   = (pred == taken_i);

  // saturating miss count
  assign miss_n = (!ok && (miss != '1)) ? miss + tllbp_pkg::MISS_W'(1) : miss;

  // saturating counter step toward the outcome
  always_comb begin
    ctr_n = ctr;
    if (taken_i) begin
      if (ctr != tllbp_pkg::CTR_MAX) ctr_n = ctr + tllbp_pkg::CTR_W'(1);
    end else begin
      if (ctr != tllbp_pkg::CTR_MIN) ctr_n = ctr - tllbp_pkg::CTR_W'(1);
    end
  end

  // write the stepped counter back into its slot
  always_comb begin
    ctrs_n = ctrs;
    for (int i = 0; i < NumCtrs; i++) begin
      if (HISTORY_BITS'(i) == hist) begin
        ctrs_n[i * tllbp_pkg::CTR_W +: tllbp_pkg::CTR_W] = ctr_n;
      end
    end
  end

  // history shift: oldest bit drops, outcome enters at the bottom
  if (HISTORY_BITS > 1) begin : g_hist_shift
    assign hist_n = {hist[HISTORY_BITS-2:0], taken_i};
  end else begin : g_hist_one
    assign hist_n = taken_i;
  end

  assign row_o = {miss_n, ctrs_n, hist_n};

  // result beat
  assign entry_ext                = ExtW'(entry_i);
  assign res_o.predicted_taken    = pred;
  assign res_o.correct            = ok;
  assign res_o.entry_used         = entry_ext[tllbp_pkg::ENTRY_OUT_W-1:0];
  assign res_o.mispredict_count   = miss_n;

endmodule

[test/tb_two_level_local_branch_predictor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-level local branch predictor: regression testbench
// Drives outcome beats with random gaps, stalls the result side at random and
// checks every result beat against an in-order mirror of the predictor state.
// Entry counts are swept through all register values between phases.
// ----------------------------------------------------------------------------

// mirror of predictor state plus the queue of results still owed
class predictor_mirror;
  localparam int ENTRIES = 16;
  localparam int PATTERNS = 8;

  logic [2:0]  history [ENTRIES];
  logic [1:0]  counters [ENTRIES][PATTERNS];
  logic [15:0] misses [ENTRIES];
  logic [2:0]  entries_log2;
  tllbp_pkg::out_beat_t expected_verdicts [$];
  int unsigned errors;

  function new();
    foreach (history[e]) begin
      history[e] = '0;
      misses[e] = '0;
    end
    foreach (counters[e, h]) counters[e][h] = tllbp_pkg::CTR_MIN;
    entries_log2 = tllbp_pkg::CFG_RESET;
    errors = 0;
  endfunction

  function void set_log2(logic [2:0] v);
    entries_log2 = v;
  endfunction

  // zero acts as one, counts above the table size clamp to it
  function logic [3:0] entry_of(logic [15:0] idx);
    logic [2:0] lg;
    lg = entries_log2;
    if (lg == 3'd0) lg = 3'd1;
    else if (lg > 3'd4) lg = 3'd4;
    return 4'(idx & ((16'd1 << lg) - 16'd1));
  endfunction

  function logic predicts_taken(logic [15:0] idx);
    logic [3:0] e;
    e = entry_of(idx);
    return counters[e][history[e]][1];
  endfunction

  // accepted input beat: work out its verdict and update the tables
  function void record_outcome(tllbp_pkg::in_beat_t b);
    logic [3:0] e;
    logic [2:0] h;
    logic [1:0] c;
    tllbp_pkg::out_beat_t r;
    e = entry_of(b.inst_index);
    h = history[e];
    c = counters[e][h];
    r.predicted_taken = c[1];
    r.correct = (c[1] == b.taken);
    if (!r.correct && misses[e] != 16'hFFFF) misses[e] = misses[e] + 16'd1;
    if (b.taken && c != tllbp_pkg::CTR_MAX) c = c + 2'd1;
    else if (!b.taken && c != tllbp_pkg::CTR_MIN) c = c - 2'd1;
    counters[e][h] = c;
    history[e] = {h[1:0], b.taken};
    r.entry_used = e;
    r.mispredict_count = misses[e];
    expected_verdicts.insert(expected_verdicts.size(), r);
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 40) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // accepted result beat against the oldest verdict owed
  task check_verdict(tllbp_pkg::out_beat_t got);
    tllbp_pkg::out_beat_t want;
    if (expected_verdicts.size() == 0) begin
      report($sformatf("result beat with none pending: %p", got));
      return;
    end
    want = expected_verdicts.pop_front();
    if (got.predicted_taken !== want.predicted_taken)
      report($sformatf("predicted_taken %b, want %b", got.predicted_taken,
                       want.predicted_taken));
    if (got.correct !== want.correct)
      report($sformatf("correct %b, want %b", got.correct, want.correct));
    if (got.entry_used !== want.entry_used)
      report($sformatf("entry_used %0d, want %0d", got.entry_used, want.entry_used));
    if (got.mispredict_count !== want.mispredict_count)
      report($sformatf("mispredict_count %0d, want %0d (entry %0d)",
                       got.mispredict_count, want.mispredict_count, want.entry_used));
  endtask
endclass

module tb_two_level_local_branch_predictor;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [tllbp_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  tllbp_pkg::in_beat_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  tllbp_pkg::out_beat_t out_data_o;

  predictor_mirror mirror = new();
  bit no_idle = 1'b0;
  int unsigned out_hold = 0;
  int unsigned out_gap = 0;
  int unsigned quiet_cycles = 0;

  two_level_local_branch_predictor DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // result side: random stall after each beat, none while no_idle is set
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (out_hold != 0) begin
      out_hold <= out_hold - 1;
    end else if (out_ready_i && out_valid_o) begin
      out_gap = no_idle ? 0 : $urandom_range(0, 9);
      if (out_gap != 0) begin
        out_hold <= out_gap - 1;
        out_ready_i <= 1'b0;
      end
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // check every accepted result beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) mirror.check_verdict(out_data_o);
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("two_level_local_branch_predictor regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input beat after a random gap; valid stays up for back-to-back beats
  task automatic send_item(tllbp_pkg::in_beat_t b);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    mirror.record_outcome(b);
  endtask

  task automatic send_dir(logic [15:0] idx, logic taken, int unsigned times);
    tllbp_pkg::in_beat_t b;
    b.inst_index = idx;
    b.taken = taken;
    repeat (times) send_item(b);
  endtask

  // drop valid and wait until every owed result has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (mirror.expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_entries_log2(logic [tllbp_pkg::CFG_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    mirror.set_log2(v);
    cfg_valid_i <= 1'b0;
  endtask

  // bursts of repeating branch patterns over a few sites, some pure noise
  task automatic run_traffic(int unsigned n_items);
    logic [15:0] site_idx [4];
    logic [7:0] site_pat [4];
    int unsigned site_len [4];
    int unsigned site_pos [4];
    int unsigned left, burst, sites, s;
    bit noise;
    tllbp_pkg::in_beat_t b;
    left = n_items;
    while (left != 0) begin
      burst = $urandom_range(8, 40);
      if (burst > left) burst = left;
      noise = ($urandom_range(0, 3) == 0);
      sites = $urandom_range(1, 4);
      for (int k = 0; k < 4; k++) begin
        site_idx[k] = 16'($urandom);
        site_pat[k] = 8'($urandom);
        site_len[k] = $urandom_range(1, 8);
        site_pos[k] = 0;
      end
      repeat (burst) begin
        if (noise) begin
          b.inst_index = 16'($urandom);
          b.taken = 1'($urandom);
        end else begin
          s = $urandom_range(0, sites - 1);
          b.inst_index = site_idx[s];
          b.taken = site_pat[s][site_pos[s] % site_len[s]];
          site_pos[s]++;
        end
        send_item(b);
      end
      left -= burst;
    end
  endtask

  initial begin : main
    logic [tllbp_pkg::CFG_W-1:0] sweep [8];
    tllbp_pkg::in_beat_t b;
    sweep = '{3'd4, 3'd0, 3'd7, 3'd2, 3'd5, 3'd3, 3'd6, 3'd1};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: two entries after reset, field extremes
    send_dir(16'h0000, 1'b0, 1);
    send_dir(16'hFFFF, 1'b1, 1);
    send_dir(16'h8000, 1'b1, 1);
    send_dir(16'h7FFF, 1'b0, 1);
    wait_idle();
    write_entries_log2(3'd4);
    // history fills with taken and its counter saturates high, then history drains to not-taken
    send_dir(16'hFFFF, 1'b1, 8);
    send_dir(16'hFFFF, 1'b0, 5);
    send_dir(16'hAAAA, 1'b1, 1);
    send_dir(16'h5555, 1'b0, 1);
    send_dir(16'h0010, 1'b1, 1);
    wait_idle();

    // always mispredict one entry back to back, then random outcomes on it
    write_entries_log2(3'd1);
    no_idle = 1'b1;
    repeat (48) begin
      b.inst_index = 16'($urandom);
      b.inst_index[0] = 1'b1;
      b.taken = ~mirror.predicts_taken(b.inst_index);
      send_item(b);
    end
    repeat (16) begin
      b.inst_index = 16'($urandom);
      b.inst_index[0] = 1'b1;
      b.taken = 1'($urandom);
      send_item(b);
    end
    wait_idle();

    // random phases across every entry count setting
    foreach (sweep[p]) begin
      no_idle = (p % 4 == 3);
      write_entries_log2(sweep[p]);
      run_traffic(225);
      wait_idle();
    end
    no_idle = 1'b0;

    wait_idle();
    if (mirror.errors == 0) begin
      $display("two_level_local_branch_predictor regression: pass");
    end else begin
      $display("two_level_local_branch_predictor regression: fail");
    end
    $finish;
  end
endmodule
